>>> src/euq_pkg.sv
// Shared types and constants for the Euler-angle to quaternion pipeline.
// Used by euq_sincos and euler_to_quaternion_top; depends on nothing else.
package euq_pkg;

  localparam int ANGLE_WIDTH  = 16;
  localparam int OUT_WIDTH    = 16;
  localparam int ANGLE_FRAC   = ANGLE_WIDTH - 3;
  localparam int OUT_FRAC     = OUT_WIDTH - 2;
  localparam int IFRAC        = 30;
  // Shift that turns a Q3.ANGLE_FRAC angle into its half angle in Q.30.
  localparam int HALF_SHIFT   = IFRAC - 1 - ANGLE_FRAC;
  localparam int SERIES_TERMS = 8;

  localparam logic signed [32:0] PI_I      = 33'sd3373259426;
  localparam logic signed [32:0] HALF_PI_I = 33'sd1686629713;
  localparam logic [31:0]        ONE_I     = 32'h4000_0000;

  // Width of the signed sine and cosine values and of unsigned magnitudes.
  localparam int CS_W  = 34;
  localparam int MAG_W = 32;

  // Register stages from an angle to its sine and cosine.
  localparam int SC_LAT = 2 * SERIES_TERMS + 4;

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] roll_angle;
    logic signed [ANGLE_WIDTH-1:0] pitch_angle;
    logic signed [ANGLE_WIDTH-1:0] yaw_angle;
  } euq_in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] quat_x;
    logic signed [OUT_WIDTH-1:0] quat_y;
    logic signed [OUT_WIDTH-1:0] quat_z;
    logic signed [OUT_WIDTH-1:0] quat_w;
  } euq_out_t;

  // Sign-magnitude value in Q.30.
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
  } euq_sm_t;

endpackage

>>> src/euq_sincos.sv
// Pipelined sine and cosine of a half angle by a truncated Taylor series.
// Depends on euq_pkg; SC_LAT register stages, advancing when en_i is high.
module euq_sincos import euq_pkg::*; (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [ANGLE_WIDTH-1:0] angle_i,
  output logic signed [CS_W-1:0]        sin_o,
  output logic signed [CS_W-1:0]        cos_o
);

  localparam int NT = SERIES_TERMS;

  // Range reduction of the half angle.
  logic signed [32:0] z, zr_d, zr_q;
  logic               fl_a_d, fl_a_q;

  always_comb begin
    z      = 33'(angle_i) <<< HALF_SHIFT;
    zr_d   = z;
    fl_a_d = 1'b0;
    if (z > HALF_PI_I) begin
      zr_d   = z - PI_I;
      fl_a_d = 1'b1;
    end else if (z < -HALF_PI_I) begin
      zr_d   = z + PI_I;
      fl_a_d = 1'b1;
    end
  end

  // Magnitude of the reduced angle.
  logic signed [32:0] zabs;
  logic [30:0]        u_q;
  logic               sn_b_q, fl_b_q;

  assign zabs = zr_q[32] ? -zr_q : zr_q;

  // Series levels: level k holds term k and the sum of terms below k.
  logic [31:0]            st_d   [NT+1];
  logic [31:0]            st_q   [NT+1];
  logic [31:0]            ct_d   [NT+1];
  logic [31:0]            ct_q   [NT+1];
  logic signed [CS_W-1:0] sacc_d [NT+1];
  logic signed [CS_W-1:0] sacc_q [NT+1];
  logic signed [CS_W-1:0] cacc_d [NT+1];
  logic signed [CS_W-1:0] cacc_q [NT+1];
  logic                   sn_d   [NT+1];
  logic                   sn_q   [NT+1];
  logic                   fl_d   [NT+1];
  logic                   fl_q   [NT+1];
  logic [31:0]            u2_d   [NT];
  logic [31:0]            u2_q   [NT];

  // Product stage of each term.
  logic [31:0]            ps_d    [NT];
  logic [31:0]            ps_q    [NT];
  logic [31:0]            pc_d    [NT];
  logic [31:0]            pc_q    [NT];
  logic signed [CS_W-1:0] saccp_d [NT];
  logic signed [CS_W-1:0] saccp_q [NT];
  logic signed [CS_W-1:0] caccp_d [NT];
  logic signed [CS_W-1:0] caccp_q [NT];
  logic                   snp_d   [NT];
  logic                   snp_q   [NT];
  logic                   flp_d   [NT];
  logic                   flp_q   [NT];
  logic [31:0]            u2p_d   [NT-1];
  logic [31:0]            u2p_q   [NT-1];

  logic [61:0] usq;
  assign usq       = 62'(u_q) * 62'(u_q);
  assign u2_d[0]   = usq[61:30];
  assign st_d[0]   = 32'(u_q);
  assign ct_d[0]   = ONE_I;
  assign sacc_d[0] = '0;
  assign cacc_d[0] = '0;
  assign sn_d[0]   = sn_b_q;
  assign fl_d[0]   = fl_b_q;

  for (genvar k = 1; k <= NT; k++) begin : g_term
    localparam int DS = (2 * k) * (2 * k + 1);
    localparam int DC = (2 * k - 1) * (2 * k);
    localparam int LS = $clog2(DS);
    localparam int LC = $clog2(DC);
    // Rounded-up reciprocals; exact floor division for any 32-bit dividend.
    localparam logic [63:0] MS = ((64'd1 << (32 + LS)) + 64'(DS) - 64'd1) / 64'(DS);
    localparam logic [63:0] MC = ((64'd1 << (32 + LC)) + 64'(DC) - 64'd1) / 64'(DC);
    localparam bit PREV_ODD = ((k - 1) % 2) == 1;

    logic [63:0] mul_s, mul_c;
    logic [64:0] div_s, div_c;

    assign mul_s = 64'(st_q[k-1]) * 64'(u2_q[k-1]);
    assign mul_c = 64'(ct_q[k-1]) * 64'(u2_q[k-1]);
    assign ps_d[k-1] = mul_s[61:30];
    assign pc_d[k-1] = mul_c[61:30];
    assign saccp_d[k-1] = PREV_ODD ? sacc_q[k-1] - $signed({2'b00, st_q[k-1]})
                                   : sacc_q[k-1] + $signed({2'b00, st_q[k-1]});
    assign caccp_d[k-1] = PREV_ODD ? cacc_q[k-1] - $signed({2'b00, ct_q[k-1]})
                                   : cacc_q[k-1] + $signed({2'b00, ct_q[k-1]});
    assign snp_d[k-1] = sn_q[k-1];
    assign flp_d[k-1] = fl_q[k-1];

    assign div_s = 65'(ps_q[k-1]) * 65'(MS[32:0]);
    assign div_c = 65'(pc_q[k-1]) * 65'(MC[32:0]);
    assign st_d[k]   = 32'(div_s >> (32 + LS));
    assign ct_d[k]   = 32'(div_c >> (32 + LC));
    assign sacc_d[k] = saccp_q[k-1];
    assign cacc_d[k] = caccp_q[k-1];
    assign sn_d[k]   = snp_q[k-1];
    assign fl_d[k]   = flp_q[k-1];

    if (k < NT) begin : g_carry
      assign u2p_d[k-1] = u2_q[k-1];
      assign u2_d[k]    = u2p_q[k-1];
    end
  end

  // Last term, then the signs from range reduction.
  localparam bit LAST_ODD = (NT % 2) == 1;
  logic signed [CS_W-1:0] s_fin, c_fin, sin_d, cos_d, sin_q, cos_q;

  always_comb begin
    s_fin = LAST_ODD ? sacc_q[NT] - $signed({2'b00, st_q[NT]})
                     : sacc_q[NT] + $signed({2'b00, st_q[NT]});
    c_fin = LAST_ODD ? cacc_q[NT] - $signed({2'b00, ct_q[NT]})
                     : cacc_q[NT] + $signed({2'b00, ct_q[NT]});
    sin_d = (sn_q[NT] ^ fl_q[NT]) ? -s_fin : s_fin;
    cos_d = fl_q[NT] ? -c_fin : c_fin;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zr_q    <= zr_d;
      fl_a_q  <= fl_a_d;
      u_q     <= zabs[30:0];
      sn_b_q  <= zr_q[32];
      fl_b_q  <= fl_a_q;
      st_q    <= st_d;
      ct_q    <= ct_d;
      sacc_q  <= sacc_d;
      cacc_q  <= cacc_d;
      sn_q    <= sn_d;
      fl_q    <= fl_d;
      u2_q    <= u2_d;
      ps_q    <= ps_d;
      pc_q    <= pc_d;
      saccp_q <= saccp_d;
      caccp_q <= caccp_d;
      snp_q   <= snp_d;
      flp_q   <= flp_d;
      u2p_q   <= u2p_d;
      sin_q   <= sin_d;
      cos_q   <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

>>> src/euler_to_quaternion_top.sv
// Roll, pitch and yaw to a normalized quaternion, fully pipelined.
// Accepts one beat per cycle unless a stalled result holds the pipeline.
// Depth is set by the 32-stage square root and the OUT_FRAC + 2 stage dividers.
// A stall on a valid result freezes every stage; nothing is lost or repeated.
// Reset clears only the per-stage valid bits. Depends on euq_pkg and euq_sincos.
module euler_to_quaternion_top import euq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  euq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output euq_out_t out_data_o
);

  localparam int SQ_STEPS = MAG_W;
  localparam int DW       = MAG_W + OUT_FRAC + 1;
  localparam int DLEV     = OUT_FRAC + 2;
  localparam int LAT      = SC_LAT + 8 + SQ_STEPS + 2 + (OUT_FRAC + 1) + 1;
  localparam logic [OUT_FRAC:0] LIM = {1'b1, {OUT_FRAC{1'b0}}};

  logic           en;
  logic [LAT-1:0] v_q;

  assign en         = !(v_q[LAT-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], in_valid_i};
    end
  end

  function automatic euq_sm_t to_sm(logic signed [CS_W-1:0] x);
    logic signed [CS_W-1:0] a;
    euq_sm_t r;
    a     = x[CS_W-1] ? -x : x;
    r.mag = a[MAG_W-1:0];
    r.neg = x[CS_W-1];
    return r;
  endfunction

  // Product of two Q.30 values, truncated toward zero.
  function automatic euq_sm_t mul_sm(euq_sm_t a, euq_sm_t b);
    logic [63:0] p;
    euq_sm_t r;
    p     = 64'(a.mag) * 64'(b.mag);
    r.mag = p[61:30];
    r.neg = a.neg ^ b.neg;
    return r;
  endfunction

  function automatic logic signed [CS_W-1:0] sm_val(euq_sm_t a);
    logic signed [CS_W-1:0] v;
    v = $signed({2'b00, a.mag});
    return a.neg ? -v : v;
  endfunction

  // Sine and cosine of the three half angles.
  logic signed [CS_W-1:0] s1, c1, s2, c2, s3, c3;

  euq_sincos u_sc_roll (
    .clk_i(clk_i), .en_i(en), .angle_i(in_data_i.roll_angle), .sin_o(s1), .cos_o(c1));
  euq_sincos u_sc_pitch (
    .clk_i(clk_i), .en_i(en), .angle_i(in_data_i.pitch_angle), .sin_o(s2), .cos_o(c2));
  euq_sincos u_sc_yaw (
    .clk_i(clk_i), .en_i(en), .angle_i(in_data_i.yaw_angle), .sin_o(s3), .cos_o(c3));

  // Product terms and components.
  euq_sm_t                s1_q, c1_q, s2_q, c2_q, s3_q, c3_q;
  euq_sm_t                s1b_q, c1b_q, cc_q, ss_q, cs_q, sc_q;
  euq_sm_t                p_q [8];
  logic signed [CS_W-1:0] q_q [4];
  euq_sm_t                qm_q [4];
  logic [63:0]            sq_q [4];
  euq_sm_t                qm6_q [4];
  logic [63:0]            s01_q, s23_q;
  euq_sm_t                qm7_q [4];

  // Square root levels; level 0 holds the sum of squares.
  logic [MAG_W+1:0] rem_d  [SQ_STEPS+1];
  logic [MAG_W+1:0] rem_q  [SQ_STEPS+1];
  logic [MAG_W-1:0] root_d [SQ_STEPS+1];
  logic [MAG_W-1:0] root_q [SQ_STEPS+1];
  logic [63:0]      sv_d   [SQ_STEPS+1];
  logic [63:0]      sv_q   [SQ_STEPS+1];
  euq_sm_t          qa_d   [SQ_STEPS+1][4];
  euq_sm_t          qa_q   [SQ_STEPS+1][4];

  always_comb begin
    logic [MAG_W+3:0] rem2;
    logic [MAG_W+3:0] trial;
    rem_d[0]  = '0;
    root_d[0] = '0;
    sv_d[0]   = s01_q + s23_q;
    qa_d[0]   = qm7_q;
    for (int i = 0; i < SQ_STEPS; i++) begin
      rem2  = {rem_q[i], sv_q[i][63:62]};
      trial = {2'b00, root_q[i], 2'b01};
      if (rem2 >= trial) begin
        rem_d[i+1]  = (MAG_W + 2)'(rem2 - trial);
        root_d[i+1] = {root_q[i][MAG_W-2:0], 1'b1};
      end else begin
        rem_d[i+1]  = rem2[MAG_W+1:0];
        root_d[i+1] = {root_q[i][MAG_W-2:0], 1'b0};
      end
      sv_d[i+1] = {sv_q[i][61:0], 2'b00};
      qa_d[i+1] = qa_q[i];
    end
  end

  // Numerators of the rounded divisions.
  logic [DW-1:0]    num_q  [4];
  logic             negn_q [4];
  logic [MAG_W-1:0] normn_q;

  // Divider levels; level 0 holds the overflow check.
  logic [DW-1:0]     r_d     [DLEV][4];
  logic [DW-1:0]     r_q     [DLEV][4];
  logic [OUT_FRAC:0] qt_d    [DLEV][4];
  logic [OUT_FRAC:0] qt_q    [DLEV][4];
  logic              sat_d   [DLEV][4];
  logic              sat_q   [DLEV][4];
  logic              negd_d  [DLEV][4];
  logic              negd_q  [DLEV][4];
  logic [MAG_W-1:0]  normd_d [DLEV];
  logic [MAG_W-1:0]  normd_q [DLEV];

  always_comb begin
    logic [DW-1:0] dv;
    for (int c = 0; c < 4; c++) begin
      r_d[0][c]    = num_q[c];
      qt_d[0][c]   = '0;
      sat_d[0][c]  = {1'b0, num_q[c]} >= (DW + 1)'({normn_q, {(OUT_FRAC + 1){1'b0}}});
      negd_d[0][c] = negn_q[c];
    end
    normd_d[0] = normn_q;
    for (int j = 0; j < DLEV - 1; j++) begin
      dv = DW'(normd_q[j]) << (OUT_FRAC - j);
      for (int c = 0; c < 4; c++) begin
        if (r_q[j][c] >= dv) begin
          r_d[j+1][c]  = r_q[j][c] - dv;
          qt_d[j+1][c] = {qt_q[j][c][OUT_FRAC-1:0], 1'b1};
        end else begin
          r_d[j+1][c]  = r_q[j][c];
          qt_d[j+1][c] = {qt_q[j][c][OUT_FRAC-1:0], 1'b0};
        end
        sat_d[j+1][c]  = sat_q[j][c];
        negd_d[j+1][c] = negd_q[j][c];
      end
      normd_d[j+1] = normd_q[j];
    end
  end

  // Clamp, sign and the identity result for a zero norm.
  logic [OUT_FRAC:0]    qv   [4];
  logic [OUT_WIDTH-1:0] comp [4];
  euq_out_t             out_d, out_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      qv[c] = (sat_q[DLEV-1][c] || qt_q[DLEV-1][c] > LIM) ? LIM : qt_q[DLEV-1][c];
      comp[c] = negd_q[DLEV-1][c] ? -OUT_WIDTH'(qv[c]) : OUT_WIDTH'(qv[c]);
    end
    if (normd_q[DLEV-1] == '0) begin
      out_d.quat_x = '0;
      out_d.quat_y = '0;
      out_d.quat_z = '0;
      out_d.quat_w = $signed(OUT_WIDTH'(LIM));
    end else begin
      out_d.quat_x = $signed(comp[0]);
      out_d.quat_y = $signed(comp[1]);
      out_d.quat_z = $signed(comp[2]);
      out_d.quat_w = $signed(comp[3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= to_sm(s1);
      c1_q  <= to_sm(c1);
      s2_q  <= to_sm(s2);
      c2_q  <= to_sm(c2);
      s3_q  <= to_sm(s3);
      c3_q  <= to_sm(c3);
      cc_q  <= mul_sm(c2_q, c3_q);
      ss_q  <= mul_sm(s2_q, s3_q);
      cs_q  <= mul_sm(c2_q, s3_q);
      sc_q  <= mul_sm(s2_q, c3_q);
      s1b_q <= s1_q;
      c1b_q <= c1_q;
      p_q[0] <= mul_sm(s1b_q, cc_q);
      p_q[1] <= mul_sm(c1b_q, ss_q);
      p_q[2] <= mul_sm(c1b_q, sc_q);
      p_q[3] <= mul_sm(s1b_q, cs_q);
      p_q[4] <= mul_sm(c1b_q, cs_q);
      p_q[5] <= mul_sm(s1b_q, sc_q);
      p_q[6] <= mul_sm(c1b_q, cc_q);
      p_q[7] <= mul_sm(s1b_q, ss_q);
      q_q[0] <= sm_val(p_q[0]) - sm_val(p_q[1]);
      q_q[1] <= sm_val(p_q[2]) + sm_val(p_q[3]);
      q_q[2] <= sm_val(p_q[4]) - sm_val(p_q[5]);
      q_q[3] <= sm_val(p_q[6]) + sm_val(p_q[7]);
      for (int c = 0; c < 4; c++) begin
        qm_q[c]  <= to_sm(q_q[c]);
        sq_q[c]  <= 64'(qm_q[c].mag) * 64'(qm_q[c].mag);
        qm6_q[c] <= qm_q[c];
        qm7_q[c] <= qm6_q[c];
        num_q[c] <= {1'b0, qa_q[SQ_STEPS][c].mag, {OUT_FRAC{1'b0}}}
                    + DW'(root_q[SQ_STEPS] >> 1);
        negn_q[c] <= qa_q[SQ_STEPS][c].neg;
      end
      s01_q   <= sq_q[0] + sq_q[1];
      s23_q   <= sq_q[2] + sq_q[3];
      rem_q   <= rem_d;
      root_q  <= root_d;
      sv_q    <= sv_d;
      qa_q    <= qa_d;
      normn_q <= root_q[SQ_STEPS];
      r_q     <= r_d;
      qt_q    <= qt_d;
      sat_q   <= sat_d;
      negd_q  <= negd_d;
      normd_q <= normd_d;
      out_q   <= out_d;
    end
  end

  assign out_valid_o = v_q[LAT-1];
  assign out_data_o  = out_q;

  // A held result must hold back the input side.
  a_stall_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while the result beat is stalled");

  // An accepted beat enters the first valid stage.
  a_enter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted beat did not enter the pipeline");

  // The x and w components of a valid result lie within plus or minus one.
  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ($signed(out_data_o.quat_x) <= $signed({1'b0, LIM}) &&
       $signed(out_data_o.quat_x) >= -$signed({1'b0, LIM}) &&
       $signed(out_data_o.quat_w) <= $signed({1'b0, LIM}) &&
       $signed(out_data_o.quat_w) >= -$signed({1'b0, LIM})))
    else $error("quaternion component out of range");

endmodule

>>> test/tb_euler_to_quaternion_top.sv
// Testbench for euler_to_quaternion_top: drives roll/pitch/yaw beats and checks
// every quaternion beat against a fixed-point predictor kept in this file.
// Depends on euq_pkg and the RTL of euler_to_quaternion_top.
module tb_euler_to_quaternion_top;
  import euq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PI_Q30      = 64'd3373259426;
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint ONE_Q30     = 64'd1 << IFRAC;
  localparam int     PIPE_DEPTH  = 64 + OUT_FRAC;
  localparam int     NUM_RANDOM  = 700;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  euq_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  euq_out_t out_data_o;

  euq_in_t  angle_queue[$];
  euq_out_t quat_queue[$];
  int       mismatches;
  bit       stim_done;
  bit       quiet_stretch;
  bit       hold_off;

  euler_to_quaternion_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint q30_mul(longint a, longint b);
    longint ma, mb, p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p  = longint'(unsigned'(64'(ma) * 64'(mb)) >> IFRAC);
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  // Sine and cosine of a Q.30 half angle via reduction to [-pi/2, pi/2].
  function automatic void half_sin_cos(input longint z, output longint sn,
                                       output longint cs);
    bit              flip;
    longint unsigned u, u2, term;
    longint          s_acc, c_acc;
    flip = 1'b0;
    if (z > HALF_PI_Q30) begin
      z -= PI_Q30;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z += PI_Q30;
      flip = 1'b1;
    end
    u  = (z < 0) ? -z : z;
    u2 = (u * u) >> IFRAC;
    term  = u;
    s_acc = u;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = ((term * u2) >> IFRAC) / longint'((2 * k) * (2 * k + 1));
      if (k & 1) s_acc -= term; else s_acc += term;
    end
    term  = ONE_Q30;
    c_acc = ONE_Q30;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = ((term * u2) >> IFRAC) / longint'((2 * k - 1) * (2 * k));
      if (k & 1) c_acc -= term; else c_acc += term;
    end
    if (z < 0) s_acc = -s_acc;
    if (flip) begin
      s_acc = -s_acc;
      c_acc = -c_acc;
    end
    sn = s_acc;
    cs = c_acc;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v  -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [OUT_WIDTH-1:0] unit_scale(longint c,
                                                             longint unsigned nrm);
    longint unsigned mag, q;
    mag = (c < 0) ? -c : c;
    q   = ((mag << OUT_FRAC) + (nrm >> 1)) / nrm;
    if (q > (64'd1 << OUT_FRAC)) q = 64'd1 << OUT_FRAC;
    if (c < 0) q = -q;
    return q[OUT_WIDTH-1:0];
  endfunction

  function automatic euq_out_t predict_quat(euq_in_t a);
    longint          s1, c1, s2, c2, s3, c3, cc, ss, cs, sc, qx, qy, qz, qw;
    longint unsigned mx, my, mz, mw, nrm;
    euq_out_t        r;
    half_sin_cos(longint'(a.roll_angle) <<< HALF_SHIFT, s1, c1);
    half_sin_cos(longint'(a.pitch_angle) <<< HALF_SHIFT, s2, c2);
    half_sin_cos(longint'(a.yaw_angle) <<< HALF_SHIFT, s3, c3);
    cc = q30_mul(c2, c3);
    ss = q30_mul(s2, s3);
    cs = q30_mul(c2, s3);
    sc = q30_mul(s2, c3);
    qx = q30_mul(s1, cc) - q30_mul(c1, ss);
    qy = q30_mul(c1, sc) + q30_mul(s1, cs);
    qz = q30_mul(c1, cs) - q30_mul(s1, sc);
    qw = q30_mul(c1, cc) + q30_mul(s1, ss);
    mx = (qx < 0) ? -qx : qx;
    my = (qy < 0) ? -qy : qy;
    mz = (qz < 0) ? -qz : qz;
    mw = (qw < 0) ? -qw : qw;
    nrm = floor_sqrt(mx * mx + my * my + mz * mz + mw * mw);
    if (nrm == 0) begin
      r = '0;
      r.quat_w = OUT_WIDTH'(1 << OUT_FRAC);
    end else begin
      r.quat_x = unit_scale(qx, nrm);
      r.quat_y = unit_scale(qy, nrm);
      r.quat_z = unit_scale(qz, nrm);
      r.quat_w = unit_scale(qw, nrm);
    end
    return r;
  endfunction

  function automatic logic [ANGLE_WIDTH-1:0] pick_angle();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
      1:       return {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
      2:       return ANGLE_WIDTH'($urandom_range(0, 8) - 4);
      default: return ANGLE_WIDTH'($urandom);
    endcase
  endfunction

  task automatic add_angles(logic [ANGLE_WIDTH-1:0] r, logic [ANGLE_WIDTH-1:0] p,
                            logic [ANGLE_WIDTH-1:0] y);
    euq_in_t a;
    a.roll_angle  = r;
    a.pitch_angle = p;
    a.yaw_angle   = y;
    angle_queue.insert(angle_queue.size(), a);
  endtask

  // Stimulus: directed extremes, angles near +-pi, then random angles.
  initial begin
    logic [ANGLE_WIDTH-1:0] amin, amax, pi_code;
    amin    = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
    amax    = {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
    pi_code = 16'd25736;  // pi in Q3.13
    add_angles('0, '0, '0);
    add_angles(amin, amin, amin);
    add_angles(amax, amax, amax);
    add_angles(amin, '0, amax);
    add_angles(amax, amin, '0);
    add_angles('0, amax, amin);
    add_angles(pi_code, '0, '0);
    add_angles(-pi_code, '0, '0);
    add_angles('0, pi_code, '0);
    add_angles('0, '0, -pi_code);
    add_angles(pi_code - 16'd1, pi_code + 16'd1, -pi_code - 16'd1);
    add_angles(16'd12868, '0, '0);  // pi/2
    add_angles('0, -16'd12868, 16'd12868);
    add_angles(16'd1, 16'hFFFF, 16'd1);
    add_angles(16'hFFFF, 16'h5555, 16'hAAAA);
    add_angles(pi_code, pi_code, pi_code);
    for (int i = 0; i < NUM_RANDOM; i++) add_angles(pick_angle(), pick_angle(), pick_angle());
    stim_done = 1'b1;
  end

  // Sender: offers a new beat when the current one is taken or none is up, with random gaps outside the quiet stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (angle_queue.size() != 0 && (quiet_stretch || $urandom_range(0, 99) >= 6)) begin
        in_valid_i <= 1'b1;
        in_data_i  <= angle_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      quat_queue.insert(quat_queue.size(), predict_quat(in_data_i));
  end

  // Receiver stall: random, or held high through a long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= hold_off || (!quiet_stretch && $urandom_range(0, 99) < 6);
  end

  always @(posedge clk_i) begin
    euq_out_t exp_q;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (quat_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected beat: got %p", out_data_o);
      end else begin
        exp_q = quat_queue.pop_front();
        if (out_data_o.quat_x !== exp_q.quat_x || out_data_o.quat_y !== exp_q.quat_y ||
            out_data_o.quat_z !== exp_q.quat_z || out_data_o.quat_w !== exp_q.quat_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %p, got %p", exp_q, out_data_o);
        end
      end
    end
  end

  // Traffic pattern: a long quiet stretch with no random gaps or stalls, then a long receiver hold-off.
  initial begin
    quiet_stretch = 1'b0;
    hold_off      = 1'b0;
    @(posedge rst_ni);
    repeat (100) @(posedge clk_i);
    quiet_stretch = 1'b1;
    repeat (200) @(posedge clk_i);
    quiet_stretch = 1'b0;
    repeat (50) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    mismatches = 0;
    rst_ni     = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && angle_queue.size() == 0);
    @(posedge clk_i);
    while (in_valid_i || quat_queue.size() != 0) @(posedge clk_i);
    repeat (2 * PIPE_DEPTH) @(posedge clk_i);
    if (mismatches == 0 && quat_queue.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
